// ===== src/tccs_pkg.sv =====
// Shared constants, types and helpers for the text console engine.
// Used by the top level and its checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int SCROLL_N   = (ROWS - 1) * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam logic [7:0]  NEWLINE_CODE  = 8'h0A;
  localparam logic [7:0]  BLANK_CODE    = 8'h20;
  localparam logic [7:0]  DEFAULT_COLOR = 8'h0F;
  localparam logic [15:0] BLANK_DEFAULT = {DEFAULT_COLOR, BLANK_CODE};

  // Configuration register select, compared with address bit 2
  localparam logic REG_TEXT_COLOR = 1'b0;

  typedef enum logic [1:0] {
    FN_PUT   = 2'd0,
    FN_BKSP  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_SCR  = 6'b001000,
    S_BLK  = 6'b010000,
    S_RES  = 6'b100000
  } state_t;

  // Linear cell address of (row, col)
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] row,
                                                  input logic [7:0] col);
    int a;
    a = int'(row) * COLUMNS + int'(col);
    return ADDR_W'(a);
  endfunction

endpackage

`default_nettype wire

// ===== src/tccs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/text_console_cursor_scroll.sv =====
// Text console engine top level: screen RAM, cursor and the sequencer that walks it.
// Depends on tccs_pkg and tccs_ram.
`timescale 1ns / 1ps
`default_nettype none

// Text console engine. Each input word carries an operation in in_tuser (put character,
// backspace, clear, read cell) and returns one result word with the cursor after the
// operation, the read cell (zero for other operations) and a scrolled flag. All cell
// traffic goes through one single-write, single-read screen RAM under a small sequencer,
// and the block takes one word at a time. A newline or wrap on the last row scrolls:
// one RAM copy per cell moves the lower rows up one line, then the bottom line is blanked.
// Clear fills every cell. After reset the block runs the same fill pass before
// in_tready goes high; configuration writes are taken throughout.

module text_console_cursor_scroll
  import tccs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // cursor_row[4:0], cursor_col[11:5],
                                       // cell_data[27:12], scrolled[28]
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [7:0]         color_r, color_nxt;
  logic               clr_op_r, clr_op_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [15:0]        res_cell_r, res_cell_nxt;
  logic               res_scr_r, res_scr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_data_r, out_data_nxt;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [15:0]        ram_wdata, ram_rdata;

  logic               in_acc;
  func_t              in_func;
  logic [7:0]         in_code;
  logic [4:0]         in_rrow;
  logic [6:0]         in_rcol;
  logic               cfg_wr;
  logic               last_row, last_col;
  logic [CNT_W-1:0]   cnt_m1;

  assign in_func = func_t'(in_tuser);
  assign in_code = in_tdata[7:0];
  assign in_rrow = in_tdata[12:8];
  assign in_rcol = in_tdata[19:13];

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TEXT_COLOR);
  assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, color_r} : 32'd0;

  assign last_row = (int'(row_r) == ROWS - 1);
  assign last_col = (int'(col_r) == COLUMNS - 1);
  assign cnt_m1   = cnt_r - 1'b1;

  tccs_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    color_nxt     = cfg_wr ? pwdata[7:0] : color_r;
    clr_op_nxt    = clr_op_r;
    rd_ok_nxt     = rd_ok_r;
    res_cell_nxt  = res_cell_r;
    res_scr_nxt   = res_scr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = cell_addr(8'(row_r), 8'(col_r));
    ram_wdata     = {color_r, in_code};
    ram_re        = 1'b0;
    ram_raddr     = cell_addr(8'(in_rrow), 8'(in_rcol));

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[ADDR_W-1:0];
        ram_wdata = BLANK_DEFAULT;
        if (int'(cnt_r) == CELL_COUNT - 1) begin
          state_nxt = clr_op_r ? S_RES : S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_cell_nxt = 16'd0;
          res_scr_nxt  = 1'b0;
          state_nxt    = S_RES;
          case (in_func)
            FN_PUT: begin
              if (in_code != NEWLINE_CODE) begin
                ram_we = 1'b1;
              end
              if (in_code == NEWLINE_CODE || last_col) begin
                col_nxt = '0;
                if (last_row) begin
                  // wrap off the bottom: copy rows up, then blank the last line
                  res_scr_nxt = 1'b1;
                  cnt_nxt     = '0;
                  state_nxt   = S_SCR;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
            FN_BKSP: begin
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
              end else if (row_r != '0) begin
                row_nxt = row_r - 1'b1;
                col_nxt = COL_W'(COLUMNS - 1);
              end
              ram_we    = 1'b1;
              ram_waddr = cell_addr(8'(row_nxt), 8'(col_nxt));
              ram_wdata = {color_r, BLANK_CODE};
            end
            FN_CLEAR: begin
              color_nxt  = DEFAULT_COLOR;
              row_nxt    = '0;
              col_nxt    = '0;
              cnt_nxt    = '0;
              clr_op_nxt = 1'b1;
              state_nxt  = S_CLR;
            end
            default: begin
              rd_ok_nxt = (int'(in_rrow) < ROWS) && (int'(in_rcol) < COLUMNS);
              ram_re    = 1'b1;
              state_nxt = S_RD;
            end
          endcase
        end
      end
      S_RD: begin
        res_cell_nxt = rd_ok_r ? ram_rdata : 16'd0;
        state_nxt    = S_RES;
      end
      S_SCR: begin
        // read one row ahead, write back the cell read in the cycle before
        ram_re    = (int'(cnt_r) < SCROLL_N);
        ram_raddr = ADDR_W'(cnt_r + CNT_W'(COLUMNS));
        ram_we    = (cnt_r != '0);
        ram_waddr = cnt_m1[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        if (int'(cnt_r) == SCROLL_N) begin
          state_nxt = S_BLK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_BLK: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[ADDR_W-1:0];
        ram_wdata = {color_r, BLANK_CODE};
        if (int'(cnt_r) == CELL_COUNT - 1) begin
          state_nxt = S_RES;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RES: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'd0, res_scr_r, res_cell_r, 7'(col_r), 5'(row_r)};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      color_r     <= DEFAULT_COLOR;
      clr_op_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      color_r     <= color_nxt;
      clr_op_r    <= clr_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r    <= rd_ok_nxt;
    res_cell_r <= res_cell_nxt;
    res_scr_r  <= res_scr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== src/tccs_checker.sv =====
// Port-level checker for the text console engine, bound to the top level.
// Depends on tccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccs_checker
  import tccs_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> int'(out_tdata[4:0]) < ROWS)
    else $error("cursor row out of range");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> int'(out_tdata[11:5]) < COLUMNS)
    else $error("cursor column out of range");

  // a scroll always leaves the cursor at the start of the bottom line
  a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[28] |->
      (out_tdata[4:0] == 5'(ROWS - 1)) && (out_tdata[11:5] == 7'd0))
    else $error("scroll left cursor off the bottom line start");

  // a scroll never reports read data
  a_scroll_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[28] |-> out_tdata[27:12] == 16'd0)
    else $error("scroll result carries cell data");

endmodule

bind text_console_cursor_scroll tccs_checker u_tccs_checker (.*);

`default_nettype wire
